// ===== rtl/vscg_pkg.sv =====
// Shared types, constants, microprogram and stroke tables of the vector stroke
// character generator. Depends on nothing; every other file uses it.
package vscg_pkg;

    // Field widths
    localparam int CHAR_W   = 8;
    localparam int CENTER_W = 15;
    localparam int SCALE_W  = 16;
    localparam int COLOR_W  = 32;
    localparam int COORD_W  = 16;
    localparam int LOCAL_W  = 4;

    localparam int SCALE_FRAC_BITS = 8;

    // Glyph store
    localparam int GLYPH_COUNT = 37;
    localparam int GLYPH_W     = 6;
    localparam int MAX_SEGS    = 10;
    localparam int SEG_IDX_W   = 4;

    localparam logic [GLYPH_W-1:0] FALLBACK_GLYPH = 6'd36;
    localparam logic [GLYPH_W-1:0] LETTER_BASE    = 6'd10;

    // Character code ranges
    localparam logic [CHAR_W-1:0] CODE_DIGIT_LO  = 8'd48;
    localparam logic [CHAR_W-1:0] CODE_DIGIT_HI  = 8'd57;
    localparam logic [CHAR_W-1:0] CODE_LETTER_LO = 8'd65;
    localparam logic [CHAR_W-1:0] CODE_LETTER_HI = 8'd90;

    // One segment: local endpoints, one nibble each
    typedef struct packed {
        logic [LOCAL_W-1:0] ax;
        logic [LOCAL_W-1:0] ay;
        logic [LOCAL_W-1:0] bx;
        logic [LOCAL_W-1:0] by;
    } t_seg;

    // Microprogram
    localparam int PROG_LEN = 4;
    localparam int PC_W     = 2;

    localparam logic [PC_W-1:0] STEP_IDLE  = 2'd0;
    localparam logic [PC_W-1:0] STEP_FETCH = 2'd1;
    localparam logic [PC_W-1:0] STEP_MUL   = 2'd2;
    localparam logic [PC_W-1:0] STEP_EMIT  = 2'd3;

    typedef enum logic {
        JC_STEP,
        JC_MORE
    } t_jcond;

    typedef struct packed {
        logic            wait_in;
        logic            fetch;
        logic            mul;
        logic            emit;
        t_jcond          jcond;
        logic [PC_W-1:0] target;
    } t_uword;

    localparam t_uword UPROG [PROG_LEN] = '{
        '{1'b1, 1'b0, 1'b0, 1'b0, JC_STEP, STEP_IDLE},
        '{1'b0, 1'b1, 1'b0, 1'b0, JC_STEP, STEP_IDLE},
        '{1'b0, 1'b0, 1'b1, 1'b0, JC_STEP, STEP_IDLE},
        '{1'b0, 1'b0, 1'b0, 1'b1, JC_MORE, STEP_FETCH}
    };

    // Datapath enables from the sequencer
    typedef struct packed {
        logic load;
        logic fetch;
        logic mul;
        logic emit;
    } t_ctrl;

    // Conditions seen by the sequencer
    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic seg_last;
    } t_status;

    localparam logic [SEG_IDX_W-1:0] GLYPH_NSEG [GLYPH_COUNT] = '{
        4'd4, 4'd1, 4'd5, 4'd5, 4'd3, 4'd5, 4'd4, 4'd2, 4'd5, 4'd4,
        4'd5, 4'd10, 4'd3, 4'd6, 4'd4, 4'd3, 4'd6, 4'd3, 4'd3, 4'd3,
        4'd3, 4'd2, 4'd4, 4'd3, 4'd4, 4'd4, 4'd7, 4'd5, 4'd5, 4'd2,
        4'd3, 4'd2, 4'd4, 4'd2, 4'd3, 4'd3, 4'd5
    };

    // Endpoints packed as {ax, ay, bx, by}; unused slots are zero
    localparam t_seg GLYPH_SEGS [GLYPH_COUNT][MAX_SEGS] = '{
        '{16'h0080, 16'h808C, 16'h8C0C, 16'h0C00, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
        '{16'h404C, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
        '{16'h0080, 16'h8086, 16'h8606, 16'h060C, 16'h0C8C, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
        '{16'h0080, 16'h8086, 16'h8606, 16'h868C, 16'h8C0C, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
        '{16'h0006, 16'h0686, 16'h808C, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
        '{16'h8000, 16'h0006, 16'h0686, 16'h868C, 16'h8C0C, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
        '{16'h000C, 16'h0C8C, 16'h8C86, 16'h8606, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
        '{16'h0080, 16'h808C, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
        '{16'h0080, 16'h808C, 16'h8C0C, 16'h0C00, 16'h0686, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
        '{16'h8000, 16'h0006, 16'h0686, 16'h808C, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
        '{16'h0C04, 16'h0440, 16'h4084, 16'h848C, 16'h0686, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
        '{16'h0060, 16'h6082, 16'h8284, 16'h8466, 16'h6606,
          16'h6688, 16'h888A, 16'h8A6C, 16'h6C0C, 16'h0C00},
        '{16'h8000, 16'h000C, 16'h0C8C, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
        '{16'h0040, 16'h4084, 16'h8488, 16'h884C, 16'h4C0C, 16'h0C00, 16'h0, 16'h0, 16'h0, 16'h0},
        '{16'h8000, 16'h000C, 16'h0C8C, 16'h0666, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
        '{16'h8000, 16'h000C, 16'h0666, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
        '{16'h8480, 16'h8000, 16'h000C, 16'h0C8C, 16'h8C88, 16'h8848, 16'h0, 16'h0, 16'h0, 16'h0},
        '{16'h000C, 16'h808C, 16'h0686, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
        '{16'h0080, 16'h8C0C, 16'h404C, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
        '{16'h808C, 16'h8C4C, 16'h4C08, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
        '{16'h000C, 16'h6006, 16'h066C, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
        '{16'h000C, 16'h0C8C, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
        '{16'h0C00, 16'h0044, 16'h4480, 16'h808C, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
        '{16'h0C00, 16'h008C, 16'h8C80, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
        '{16'h0080, 16'h808C, 16'h8C0C, 16'h0C00, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
        '{16'h0C00, 16'h0080, 16'h8086, 16'h8606, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
        '{16'h0080, 16'h8088, 16'h8888, 16'h884C, 16'h4C0C,
          16'h0C00, 16'h488C, 16'h0, 16'h0, 16'h0},
        '{16'h0C00, 16'h0080, 16'h8086, 16'h8606, 16'h068C, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
        '{16'h8000, 16'h0006, 16'h0686, 16'h868C, 16'h8C0C, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
        '{16'h0080, 16'h404C, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
        '{16'h000C, 16'h0C8C, 16'h8C80, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
        '{16'h004C, 16'h4C80, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
        '{16'h000C, 16'h0C48, 16'h488C, 16'h8C80, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
        '{16'h008C, 16'h800C, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
        '{16'h0044, 16'h4480, 16'h444C, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
        '{16'h0080, 16'h800C, 16'h0C8C, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
        '{16'h0080, 16'h8086, 16'h8606, 16'h0608, 16'h0A0C, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0}
    };

endpackage

// ===== rtl/vscg_in_if.sv =====
// Character request channel: valid/ready handshake plus the character payload.
// Depends on vscg_pkg for field widths.
interface vscg_in_if;
    logic                                  valid;
    logic                                  ready;
    logic        [vscg_pkg::CHAR_W-1:0]    char_code;
    logic signed [vscg_pkg::CENTER_W-1:0]  center_x;
    logic signed [vscg_pkg::CENTER_W-1:0]  center_y;
    logic        [vscg_pkg::SCALE_W-1:0]   scale_q8_8;
    logic        [vscg_pkg::COLOR_W-1:0]   color_rgba;

    modport source (output valid, char_code, center_x, center_y, scale_q8_8, color_rgba,
                    input ready);
    modport sink   (input valid, char_code, center_x, center_y, scale_q8_8, color_rgba,
                    output ready);
endinterface

// ===== rtl/vscg_out_if.sv =====
// Segment request channel: valid/ready handshake plus one line segment.
// Depends on vscg_pkg for field widths.
interface vscg_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [vscg_pkg::COORD_W-1:0]  start_x;
    logic signed [vscg_pkg::COORD_W-1:0]  start_y;
    logic signed [vscg_pkg::COORD_W-1:0]  end_x;
    logic signed [vscg_pkg::COORD_W-1:0]  end_y;
    logic        [vscg_pkg::COLOR_W-1:0]  seg_color;
    logic                                 last_segment;

    modport source (output valid, start_x, start_y, end_x, end_y, seg_color, last_segment,
                    input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, seg_color, last_segment,
                    output ready);
endinterface

// ===== rtl/vscg_sequencer.sv =====
// Microcode sequencer: step counter over the program table, stalls, jumps and
// the segment counter. Depends on vscg_pkg for the program and control types.
module vscg_sequencer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  vscg_pkg::t_status                 i_stat,
    output vscg_pkg::t_ctrl                   o_ctrl,
    output logic                              o_in_ready,
    output logic [vscg_pkg::SEG_IDX_W-1:0]    o_seg_idx,
    output logic [vscg_pkg::PC_W-1:0]         o_pc
);

    logic [vscg_pkg::PC_W-1:0]      r_pc;
    logic [vscg_pkg::PC_W-1:0]      n_pc;
    logic [vscg_pkg::SEG_IDX_W-1:0] r_seg_idx;
    logic [vscg_pkg::SEG_IDX_W-1:0] n_seg_idx;
    vscg_pkg::t_uword               w_uw;
    logic                           w_stall;

    assign w_uw    = vscg_pkg::UPROG[r_pc];
    assign w_stall = (w_uw.wait_in && !i_stat.in_valid) || (w_uw.emit && !i_stat.out_free);

    always_comb begin
        n_pc      = r_pc;
        n_seg_idx = r_seg_idx;
        if (!w_stall) begin
            if (w_uw.wait_in) begin
                n_seg_idx = '0;
            end
            unique case (w_uw.jcond)
                vscg_pkg::JC_MORE: begin
                    if (!i_stat.seg_last) begin
                        n_pc      = w_uw.target;
                        n_seg_idx = r_seg_idx + 1'b1;
                    end else begin
                        n_pc = (r_pc == vscg_pkg::PC_W'(vscg_pkg::PROG_LEN - 1)) ?
                               '0 : r_pc + 1'b1;
                    end
                end
                default: begin
                    n_pc = (r_pc == vscg_pkg::PC_W'(vscg_pkg::PROG_LEN - 1)) ?
                           '0 : r_pc + 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= vscg_pkg::STEP_IDLE;
            r_seg_idx <= '0;
        end else begin
            r_pc      <= n_pc;
            r_seg_idx <= n_seg_idx;
        end
    end

    assign o_ctrl.load  = w_uw.wait_in && i_stat.in_valid;
    assign o_ctrl.fetch = w_uw.fetch;
    assign o_ctrl.mul   = w_uw.mul;
    assign o_ctrl.emit  = w_uw.emit && i_stat.out_free;
    assign o_in_ready   = w_uw.wait_in;
    assign o_seg_idx    = r_seg_idx;
    assign o_pc         = r_pc;

endmodule

// ===== rtl/vscg_datapath.sv =====
// Datapath: held operands, stroke table fetch, four scale multipliers and the
// place/saturate stage into the output register. Depends on vscg_pkg.
module vscg_datapath #(
    parameter int SCALE_FRAC_BITS = vscg_pkg::SCALE_FRAC_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  vscg_pkg::t_ctrl                       i_ctrl,
    input  logic [vscg_pkg::SEG_IDX_W-1:0]        i_seg_idx,
    input  logic [vscg_pkg::CHAR_W-1:0]           i_char_code,
    input  logic signed [vscg_pkg::CENTER_W-1:0]  i_center_x,
    input  logic signed [vscg_pkg::CENTER_W-1:0]  i_center_y,
    input  logic [vscg_pkg::SCALE_W-1:0]          i_scale,
    input  logic [vscg_pkg::COLOR_W-1:0]          i_color,
    input  logic                                  i_out_ready,
    output logic                                  o_out_free,
    output logic                                  o_seg_last,
    output logic                                  o_out_valid,
    output logic signed [vscg_pkg::COORD_W-1:0]   o_start_x,
    output logic signed [vscg_pkg::COORD_W-1:0]   o_start_y,
    output logic signed [vscg_pkg::COORD_W-1:0]   o_end_x,
    output logic signed [vscg_pkg::COORD_W-1:0]   o_end_y,
    output logic [vscg_pkg::COLOR_W-1:0]          o_seg_color,
    output logic                                  o_last_segment
);

    localparam int CW = vscg_pkg::CENTER_W;
    localparam int PW = vscg_pkg::LOCAL_W + vscg_pkg::SCALE_W;
    localparam int SW = ((CW + SCALE_FRAC_BITS > PW) ? CW + SCALE_FRAC_BITS : PW) + 2;
    localparam logic signed [SW-1:0] SAT_HI = SW'(32767);
    localparam logic signed [SW-1:0] SAT_LO = SW'(-32768);

    logic [vscg_pkg::GLYPH_W-1:0]     r_glyph;
    logic signed [CW-1:0]             r_cx;
    logic signed [CW-1:0]             r_cy;
    logic [vscg_pkg::SCALE_W-1:0]     r_scale;
    logic [vscg_pkg::COLOR_W-1:0]     r_color;
    vscg_pkg::t_seg                   r_seg;
    logic                             r_last;
    logic [PW-1:0]                    r_prod [4];
    logic                             r_out_valid;
    logic [vscg_pkg::COORD_W-1:0]     r_coord [4];
    logic                             r_out_last;
    logic [vscg_pkg::COLOR_W-1:0]     r_out_color;
    logic [vscg_pkg::GLYPH_W-1:0]     w_glyph;
    logic [vscg_pkg::LOCAL_W-1:0]     w_local [4];

    // local*scale + centre, truncated toward zero, saturated to 16 bits
    function automatic logic [vscg_pkg::COORD_W-1:0] place(
        input logic [PW-1:0]        prod,
        input logic signed [CW-1:0] c
    );
        logic signed [SW-1:0] s;
        logic signed [SW-1:0] v;
        s = $signed({{(SW-PW){1'b0}}, prod}) + ($signed({{(SW-CW){c[CW-1]}}, c}) <<< SCALE_FRAC_BITS);
        if (s < 0) begin
            s = s + $signed({{(SW-SCALE_FRAC_BITS){1'b0}}, {SCALE_FRAC_BITS{1'b1}}});
        end
        v = s >>> SCALE_FRAC_BITS;
        if (v > SAT_HI) begin
            return 16'h7FFF;
        end else if (v < SAT_LO) begin
            return 16'h8000;
        end
        return v[vscg_pkg::COORD_W-1:0];
    endfunction

    always_comb begin
        if (i_char_code >= vscg_pkg::CODE_DIGIT_LO && i_char_code <= vscg_pkg::CODE_DIGIT_HI) begin
            w_glyph = vscg_pkg::GLYPH_W'(i_char_code - vscg_pkg::CODE_DIGIT_LO);
        end else if (i_char_code >= vscg_pkg::CODE_LETTER_LO &&
                     i_char_code <= vscg_pkg::CODE_LETTER_HI) begin
            w_glyph = vscg_pkg::GLYPH_W'(i_char_code - vscg_pkg::CODE_LETTER_LO) +
                      vscg_pkg::LETTER_BASE;
        end else begin
            w_glyph = vscg_pkg::FALLBACK_GLYPH;
        end
    end

    assign w_local[0] = r_seg.ax;
    assign w_local[1] = r_seg.ay;
    assign w_local[2] = r_seg.bx;
    assign w_local[3] = r_seg.by;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_glyph <= w_glyph;
            r_cx    <= i_center_x;
            r_cy    <= i_center_y;
            r_scale <= i_scale;
            r_color <= i_color;
        end
        if (i_ctrl.fetch) begin
            r_seg  <= vscg_pkg::GLYPH_SEGS[r_glyph][i_seg_idx];
            r_last <= (i_seg_idx == vscg_pkg::GLYPH_NSEG[r_glyph] - 1'b1);
        end
        if (i_ctrl.mul) begin
            for (int k = 0; k < 4; k++) begin
                r_prod[k] <= PW'(w_local[k]) * PW'(r_scale);
            end
        end
        if (i_ctrl.emit) begin
            r_coord[0]  <= place(r_prod[0], r_cx);
            r_coord[1]  <= place(r_prod[1], r_cy);
            r_coord[2]  <= place(r_prod[2], r_cx);
            r_coord[3]  <= place(r_prod[3], r_cy);
            r_out_last  <= r_last;
            r_out_color <= r_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_free     = !r_out_valid || i_out_ready;
    assign o_seg_last     = r_last;
    assign o_out_valid    = r_out_valid;
    assign o_start_x      = r_coord[0];
    assign o_start_y      = r_coord[1];
    assign o_end_x        = r_coord[2];
    assign o_end_y        = r_coord[3];
    assign o_seg_color    = r_out_color;
    assign o_last_segment = r_out_last;

endmodule

// ===== rtl/vector_stroke_char_generator_core.sv =====
// Vector stroke character generator, top level. Ties the microcode sequencer to
// the datapath and the two stream channels. Depends on vscg_pkg and both interfaces.
//
// One character request (code, centre, Q-format scale, colour) becomes between one
// and ten segment requests, in table order, each with both endpoints scaled by the
// scale, moved by the centre, truncated toward zero and saturated to 16 bits; the
// glyph's final segment carries last_segment. Digits and capitals have glyphs; any
// other code draws a question mark. A character goes through one step to take the
// request, then for each segment a table fetch, a multiply and a place/emit step
// of the four-step microprogram. The emit step stalls while the output register
// still holds an untaken segment; the next character request is taken while the
// final segment of the previous one waits. SCALE_FRAC_BITS sets the scale's
// fraction bits (4 to 16).
module vector_stroke_char_generator_core #(
    parameter int SCALE_FRAC_BITS = vscg_pkg::SCALE_FRAC_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    vscg_in_if.sink    i_in,
    vscg_out_if.source o_out
);

    vscg_pkg::t_ctrl                  w_ctrl;
    vscg_pkg::t_status                w_stat;
    logic                             w_in_ready;
    logic [vscg_pkg::SEG_IDX_W-1:0]   w_seg_idx;
    logic [vscg_pkg::PC_W-1:0]        w_pc;
    logic                             w_out_free;
    logic                             w_seg_last;

    // Gather the conditions the microprogram tests
    assign w_stat.in_valid = i_in.valid;
    assign w_stat.out_free = w_out_free;
    assign w_stat.seg_last = w_seg_last;

    vscg_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_stat     (w_stat),
        .o_ctrl     (w_ctrl),
        .o_in_ready (w_in_ready),
        .o_seg_idx  (w_seg_idx),
        .o_pc       (w_pc)
    );

    vscg_datapath #(
        .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (w_ctrl),
        .i_seg_idx      (w_seg_idx),
        .i_char_code    (i_in.char_code),
        .i_center_x     (i_in.center_x),
        .i_center_y     (i_in.center_y),
        .i_scale        (i_in.scale_q8_8),
        .i_color        (i_in.color_rgba),
        .i_out_ready    (o_out.ready),
        .o_out_free     (w_out_free),
        .o_seg_last     (w_seg_last),
        .o_out_valid    (o_out.valid),
        .o_start_x      (o_out.start_x),
        .o_start_y      (o_out.start_y),
        .o_end_x        (o_out.end_x),
        .o_end_y        (o_out.end_y),
        .o_seg_color    (o_out.seg_color),
        .o_last_segment (o_out.last_segment)
    );

    // Take a request only in the idle step
    assign i_in.ready = w_in_ready;

    // A taken request always moves straight on to the first table fetch
    a_accept_to_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (w_pc == vscg_pkg::STEP_FETCH))
        else $error("request taken but sequencer did not advance to fetch");

    // Never overwrite a segment that the sink has not yet taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.emit |-> (!o_out.valid || o_out.ready))
        else $error("output register loaded while holding an untaken segment");

    // The segment counter stays inside the stroke table row
    a_seg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pc != vscg_pkg::STEP_IDLE) |-> (w_seg_idx < vscg_pkg::SEG_IDX_W'(vscg_pkg::MAX_SEGS)))
        else $error("segment index ran past the glyph table");

endmodule

// ===== tb/sv/vscg_segment_checker.sv =====
// Segment checker for the vector stroke character generator: watches both request
// channels, predicts every segment of each accepted character and compares in order.
// Depends on vscg_pkg and the two channel interfaces.
module vscg_segment_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    vscg_in_if    i_req,
    vscg_out_if   i_seg,
    output int    o_fail_count,
    output int    o_pending,
    output int    o_seg_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import vscg_pkg::*;

    typedef struct packed {
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [COORD_W-1:0] ex;
        logic signed [COORD_W-1:0] ey;
        logic [COLOR_W-1:0]        color;
        logic                      last;
    } t_exp_seg;

    // Points as x,y nibbles and segments as point-index nibbles, first entry leftmost
    typedef struct {
        int          nseg;
        logic [79:0] pts;
        logic [79:0] links;
    } t_stroke;

    t_exp_seg expected_segs[$];
    t_exp_seg exp_seg;
    t_exp_seg got_seg;

    logic [GLYPH_W-1:0]         held_glyph;
    logic [SEG_IDX_W-1:0]       held_seg_index;
    logic signed [CENTER_W-1:0] held_cx;
    logic signed [CENTER_W-1:0] held_cy;
    logic [SCALE_W-1:0]         held_scale;
    logic [COLOR_W-1:0]         held_color;

    function automatic t_stroke stroke_table(logic [GLYPH_W-1:0] g);
        t_stroke     st;
        logic [79:0] p;
        logic [79:0] k;
        int          np;
        int          ns;
        case (g)
            6'd0:  begin p = 80'h00808C0C;             np = 4;  k = 80'h01122330;   ns = 4; end
            6'd1:  begin p = 80'h404C;                 np = 2;  k = 80'h01;         ns = 1; end
            6'd2:  begin p = 80'h008086060C8C;         np = 6;  k = 80'h0112233445; ns = 5; end
            6'd3:  begin p = 80'h008086068C0C;         np = 6;  k = 80'h0112232445; ns = 5; end
            6'd4:  begin p = 80'h000686808C;           np = 5;  k = 80'h011234;     ns = 3; end
            6'd5:  begin p = 80'h800006868C0C;         np = 6;  k = 80'h0112233445; ns = 5; end
            6'd6:  begin p = 80'h000C8C8606;           np = 5;  k = 80'h01122334;   ns = 4; end
            6'd7:  begin p = 80'h00808C;               np = 3;  k = 80'h0112;       ns = 2; end
            6'd8:  begin p = 80'h00808C0C0686;         np = 6;  k = 80'h0112233045; ns = 5; end
            6'd9:  begin p = 80'h800006868C;           np = 5;  k = 80'h01122304;   ns = 4; end
            6'd10: begin p = 80'h0C0440848C0686;       np = 7;  k = 80'h0112233456; ns = 5; end
            6'd11: begin
                p  = 80'h006082846606888A6C0C; np = 10;
                k  = 80'h01122334454667788990; ns = 10;
            end
            6'd12: begin p = 80'h80000C8C;             np = 4;  k = 80'h011223;     ns = 3; end
            6'd13: begin p = 80'h004084884C0C;         np = 6;  k = 80'h011223344550; ns = 6; end
            6'd14: begin p = 80'h80000C8C0666;         np = 6;  k = 80'h01122345;   ns = 4; end
            6'd15: begin p = 80'h80000C0666;           np = 5;  k = 80'h011234;     ns = 3; end
            6'd16: begin p = 80'h8480000C8C8848;       np = 7;  k = 80'h011223344556; ns = 6; end
            6'd17: begin p = 80'h000C808C0686;         np = 6;  k = 80'h012345;     ns = 3; end
            6'd18: begin p = 80'h00808C0C404C;         np = 6;  k = 80'h012345;     ns = 3; end
            6'd19: begin p = 80'h808C4C08;             np = 4;  k = 80'h011223;     ns = 3; end
            6'd20: begin p = 80'h000C60066C;           np = 5;  k = 80'h012334;     ns = 3; end
            6'd21: begin p = 80'h000C8C;               np = 3;  k = 80'h0112;       ns = 2; end
            6'd22: begin p = 80'h0C0044808C;           np = 5;  k = 80'h01122334;   ns = 4; end
            6'd23: begin p = 80'h0C008C80;             np = 4;  k = 80'h011223;     ns = 3; end
            6'd24: begin p = 80'h00808C0C;             np = 4;  k = 80'h01122330;   ns = 4; end
            6'd25: begin p = 80'h0C00808606;           np = 5;  k = 80'h01122334;   ns = 4; end
            6'd26: begin p = 80'h008088884C0C488C;     np = 8;  k = 80'h01122334455067; ns = 7; end
            6'd27: begin p = 80'h0C008086068C;         np = 6;  k = 80'h0112233445; ns = 5; end
            6'd28: begin p = 80'h800006868C0C;         np = 6;  k = 80'h0112233445; ns = 5; end
            6'd29: begin p = 80'h0080404C;             np = 4;  k = 80'h0123;       ns = 2; end
            6'd30: begin p = 80'h00808C0C;             np = 4;  k = 80'h033221;     ns = 3; end
            6'd31: begin p = 80'h004C80;               np = 3;  k = 80'h0112;       ns = 2; end
            6'd32: begin p = 80'h000C488C80;           np = 5;  k = 80'h01122334;   ns = 4; end
            6'd33: begin p = 80'h00808C0C;             np = 4;  k = 80'h0213;       ns = 2; end
            6'd34: begin p = 80'h0044804C;             np = 4;  k = 80'h011213;     ns = 3; end
            6'd35: begin p = 80'h00808C0C;             np = 4;  k = 80'h011332;     ns = 3; end
            // question mark, drawn for every code without a glyph
            default: begin p = 80'h00808606080A0C;     np = 7;  k = 80'h0112233456; ns = 5; end
        endcase
        st.nseg  = ns;
        st.pts   = p << (80 - 8 * np);
        st.links = k << (80 - 8 * ns);
        return st;
    endfunction

    // local*scale + centre, truncated toward zero, saturated to the coordinate width
    function automatic logic signed [COORD_W-1:0] place_coord(logic [LOCAL_W-1:0] loc,
                                                              logic signed [CENTER_W-1:0] centre,
                                                              logic [SCALE_W-1:0] scale);
        longint one;
        longint total;
        longint v;
        one   = longint'(1) << SCALE_FRAC_BITS;
        total = longint'(loc) * longint'(scale) + longint'(centre) * one;
        v     = total / one;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[COORD_W-1:0];
    endfunction

    task automatic predict_strokes(input logic [CHAR_W-1:0] code,
                                   input logic signed [CENTER_W-1:0] cx,
                                   input logic signed [CENTER_W-1:0] cy,
                                   input logic [SCALE_W-1:0] scale,
                                   input logic [COLOR_W-1:0] color);
        t_stroke  st;
        t_exp_seg s;
        int       a;
        int       b;
        if (code >= CODE_DIGIT_LO && code <= CODE_DIGIT_HI)
            held_glyph = GLYPH_W'(code - CODE_DIGIT_LO);
        else if (code >= CODE_LETTER_LO && code <= CODE_LETTER_HI)
            held_glyph = GLYPH_W'(code - CODE_LETTER_LO) + LETTER_BASE;
        else
            held_glyph = FALLBACK_GLYPH;
        held_cx    = cx;
        held_cy    = cy;
        held_scale = scale;
        held_color = color;
        st = stroke_table(held_glyph);
        for (int k = 0; k < st.nseg; k++) begin
            a = int'(st.links[79 - 8 * k -: 4]);
            b = int'(st.links[75 - 8 * k -: 4]);
            s.sx    = place_coord(st.pts[79 - 8 * a -: 4], held_cx, held_scale);
            s.sy    = place_coord(st.pts[75 - 8 * a -: 4], held_cy, held_scale);
            s.ex    = place_coord(st.pts[79 - 8 * b -: 4], held_cx, held_scale);
            s.ey    = place_coord(st.pts[75 - 8 * b -: 4], held_cy, held_scale);
            s.color = held_color;
            s.last  = (k == st.nseg - 1);
            expected_segs.push_back(s);
            held_seg_index = SEG_IDX_W'(k);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_segs.delete();
            held_glyph     = '0;
            held_seg_index = '0;
            held_cx        = '0;
            held_cy        = '0;
            held_scale     = '0;
            held_color     = '0;
            o_fail_count   = 0;
            o_seg_count    = 0;
        end else begin
            if (i_seg.valid && i_seg.ready) begin
                got_seg = '{i_seg.start_x, i_seg.start_y, i_seg.end_x, i_seg.end_y,
                            i_seg.seg_color, i_seg.last_segment};
                o_seg_count++;
                if (expected_segs.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t: segment with none expected: (%0d,%0d)-(%0d,%0d) %h %b",
                                 $realtime, got_seg.sx, got_seg.sy, got_seg.ex, got_seg.ey,
                                 got_seg.color, got_seg.last);
                    o_fail_count++;
                end else begin
                    exp_seg = expected_segs.pop_front();
                    if (got_seg !== exp_seg) begin
                        if (o_fail_count < 10)
                            $display({"%0t: segment mismatch: expected (%0d,%0d)-(%0d,%0d) ",
                                      "%h last %b, got (%0d,%0d)-(%0d,%0d) %h last %b"},
                                     $realtime, exp_seg.sx, exp_seg.sy, exp_seg.ex,
                                     exp_seg.ey, exp_seg.color, exp_seg.last, got_seg.sx,
                                     got_seg.sy, got_seg.ex, got_seg.ey, got_seg.color,
                                     got_seg.last);
                        o_fail_count++;
                    end
                end
            end
            if (i_req.valid && i_req.ready)
                predict_strokes(i_req.char_code, i_req.center_x, i_req.center_y,
                                i_req.scale_q8_8, i_req.color_rgba);
        end
        o_pending = expected_segs.size();
    end

endmodule

// ===== tb/sv/tb_vector_stroke_char_generator_core.sv =====
// Top of the testbench for the vector stroke character generator: clock, reset,
// character requests and segment back-pressure, plus the verdict.
// Depends on vscg_pkg, both channel interfaces, the core and vscg_segment_checker.
module tb_vector_stroke_char_generator_core;
    timeunit 1ns;
    timeprecision 1ps;

    import vscg_pkg::*;

    logic clk = 1'b0;
    logic rst_n;

    // Stimulus knobs for the request driver and the segment receiver
    bit src_idles;
    bit sink_stalls;
    int sink_hold_cycles;
    int chars_sent;

    int fail_count;
    int pending_segs;
    int seg_count;

    vscg_in_if  char_req ();
    vscg_out_if seg_rsp ();

    vector_stroke_char_generator_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (char_req),
        .o_out   (seg_rsp)
    );

    vscg_segment_checker u_seg_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req        (char_req),
        .i_seg        (seg_rsp),
        .o_fail_count (fail_count),
        .o_pending    (pending_segs),
        .o_seg_count  (seg_count)
    );

    always #4 clk = ~clk;

    // Hard stop: far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    // Offer one character request from a falling edge and hold it until taken.
    // Enter and leave on a falling edge; valid stays high on exit, so the next
    // call either drops it for a gap or overwrites the payload in the same step.
    task automatic send_char(input logic [CHAR_W-1:0] code,
                             input logic signed [CENTER_W-1:0] cx,
                             input logic signed [CENTER_W-1:0] cy,
                             input logic [SCALE_W-1:0] scale,
                             input logic [COLOR_W-1:0] color);
        int gap;
        gap = 0;
        if (src_idles && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 19);
        if (gap != 0) begin
            char_req.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        char_req.valid      = 1'b1;
        char_req.char_code  = code;
        char_req.center_x   = cx;
        char_req.center_y   = cy;
        char_req.scale_q8_8 = scale;
        char_req.color_rgba = color;
        // the request goes at the first rising edge that sees ready
        @(posedge clk);
        while (!char_req.ready)
            @(posedge clk);
        chars_sent++;
        @(negedge clk);
    endtask

    // Segment receiver: drive ready on falling edges. A pending long hold-off wins
    // over the random stall bursts; otherwise take every segment.
    initial begin
        seg_rsp.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (sink_hold_cycles != 0) begin
                seg_rsp.ready = 1'b0;
                repeat (sink_hold_cycles) @(negedge clk);
                sink_hold_cycles = 0;
                seg_rsp.ready = 1'b1;
            end else if (sink_stalls && $urandom_range(0, 7) == 0) begin
                seg_rsp.ready = 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge clk);
                seg_rsp.ready = 1'b1;
            end else begin
                seg_rsp.ready = 1'b1;
            end
        end
    end

    initial begin
        logic [CHAR_W-1:0]          code;
        logic signed [CENTER_W-1:0] cx;
        logic signed [CENTER_W-1:0] cy;
        logic [SCALE_W-1:0]         scale;
        int                         idx;
        int                         pick;

        char_req.valid      = 1'b0;
        char_req.char_code  = '0;
        char_req.center_x   = '0;
        char_req.center_y   = '0;
        char_req.scale_q8_8 = '0;
        char_req.color_rgba = '0;
        src_idles        = 1'b0;
        sink_stalls      = 1'b0;
        sink_hold_cycles = 0;
        chars_sent       = 0;

        // Hold reset low, release on a falling edge
        rst_n = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // Directed: code extremes and the bytes either side of each glyph range
        send_char(8'h00, 0, 0, 16'h0100, 32'h0000_0000);
        send_char(8'hFF, 0, 0, 16'h0100, 32'hFFFF_FFFF);
        send_char(CODE_DIGIT_LO - 8'd1, 10, 20, 16'h0200, 32'h1234_5678);
        send_char(CODE_DIGIT_LO, 100, -100, 16'h0100, 32'hA5A5_5A5A);
        send_char(CODE_DIGIT_HI, -200, 300, 16'h0300, 32'h5A5A_A5A5);
        send_char(CODE_DIGIT_HI + 8'd1, 0, 0, 16'h0100, 32'h0F0F_F0F0);
        send_char(CODE_LETTER_LO - 8'd1, 7, 7, 16'h0180, 32'hF0F0_0F0F);
        send_char(CODE_LETTER_LO, -5, -5, 16'h0400, 32'h8000_0001);
        send_char(CODE_LETTER_HI, 1000, 1000, 16'h0100, 32'h7FFF_FFFE);
        send_char(CODE_LETTER_HI + 8'd1, -1000, 50, 16'h0100, 32'hDEAD_BEEF);
        // ten segments, the longest glyph; then the table oddities
        send_char("B", 0, 0, 16'h0A80, 32'hCAFE_F00D);
        send_char("Q", 33, -33, 16'h0140, 32'h0102_0304);
        send_char("X", -33, 33, 16'h0100, 32'h0506_0708);
        send_char("U", 0, 0, 16'h0100, 32'h090A_0B0C);
        send_char("Z", 12, 12, 16'h0100, 32'h0D0E_0F10);
        // zero scale collapses every endpoint onto the centre
        send_char("M", 1234, -4321, 16'h0000, 32'h1111_1111);
        send_char(8'h3F, -16384, 16383, 16'h0000, 32'h2222_2222);
        // centre and scale extremes, the nearest the coordinates get to saturation
        send_char("8", 16383, 16383, 16'hFFFF, 32'h3333_3333);
        send_char("8", -16384, -16384, 16'hFFFF, 32'h4444_4444);
        send_char("W", 16383, -16384, 16'hFFFF, 32'h5555_5555);
        // negative sums with a fraction must truncate toward zero, not floor
        send_char("1", -1, -1, 16'h0001, 32'h6666_6666);
        send_char("7", -3, -7, 16'h0080, 32'h7777_7777);
        send_char("K", -16384, -16384, 16'h0055, 32'h8888_8888);

        // Random: a sweep of every glyph first, then a mix of glyphs and raw bytes
        for (int i = 0; i < 220; i++) begin
            // keep the sender eager while the receiver holds off, and drop all idling
            // for the final stretch
            src_idles   = (i < 180) && !(i >= 60 && i < 75);
            sink_stalls = (i < 180);

            if (i == 60)
                sink_hold_cycles = 250;
            if (i == 120) begin
                // drop the request and wait for every segment before going on
                char_req.valid = 1'b0;
                wait (pending_segs == 0);
                @(negedge clk);
            end

            idx  = (i < 37) ? i : $urandom_range(0, 36);
            pick = $urandom_range(0, 9);
            if (i >= 37 && pick >= 7)
                code = CHAR_W'($urandom_range(0, 255));
            else if (idx < 10)
                code = CHAR_W'(CODE_DIGIT_LO + idx);
            else if (idx < 36)
                code = CHAR_W'(CODE_LETTER_LO + idx - 10);
            else
                code = 8'h21;

            if ($urandom_range(0, 9) < 3) begin
                cx = CENTER_W'($urandom);
                cy = CENTER_W'($urandom);
            end else begin
                cx = CENTER_W'($urandom_range(0, 8191) - 4096);
                cy = CENTER_W'($urandom_range(0, 8191) - 4096);
            end

            pick = $urandom_range(0, 9);
            if (pick == 0)
                scale = '0;
            else if (pick <= 5)
                scale = SCALE_W'($urandom_range(0, 16'h0600));
            else if (pick <= 7)
                scale = SCALE_W'($urandom);
            else
                scale = SCALE_W'($urandom_range(1, 255));

            send_char(code, cx, cy, scale, $urandom);
        end
        char_req.valid = 1'b0;

        // Drain, then let the block settle for longer than one full glyph takes
        wait (pending_segs == 0);
        repeat (40) @(posedge clk);

        $display("Drew %0d characters (every glyph, the fallback, zero and full-range scales)",
                 chars_sent);
        $display("and checked %0d segments through random stalls and a 250-cycle hold-off.",
                 seg_count);
        if (fail_count == 0 && pending_segs == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
